@@ rtl/mcf_pkg.sv @@
// mcf_pkg: shared types and constants of the motor CAN command framer
// used by mcf_front, mcf_queue, mcf_back and motor_can_command_framer
// no dependencies
package mcf_pkg;

  // result kinds
  localparam logic [1:0] KIND_TX  = 2'd0;
  localparam logic [1:0] KIND_RX  = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  // protocol codes
  localparam logic [7:0] VELOCITY_FN   = 8'hF6;
  localparam logic [7:0] REPLY_HEAD    = 8'h36;
  localparam logic [7:0] REPLY_TAIL    = 8'h6B;
  localparam logic [3:0] REPLY_MIN_LEN = 4'd7;

  // frame positions cleared by the limit guard
  localparam int GUARD_LO = 4;
  localparam int GUARD_HI = 5;

  // motors that have limit registers
  localparam int LIMIT_MOTORS = 3;
  // wide enough for any motor count up to eight
  localparam int MOTOR_IDX_W  = 3;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // register file
  localparam int         CFG_ADDR_W       = 5;
  localparam logic [2:0] REG_MIN_POS_M0   = 3'd0;
  localparam logic [2:0] REG_MAX_POS_M0   = 3'd1;
  localparam logic [2:0] REG_MIN_POS_M1   = 3'd2;
  localparam logic [2:0] REG_MAX_POS_M1   = 3'd3;
  localparam logic [2:0] REG_MIN_POS_M2   = 3'd4;
  localparam logic [2:0] REG_MAX_POS_M2   = 3'd5;
  localparam logic [2:0] REG_LIMITS_VALID = 3'd6;

  // classified item as it travels from front to back
  typedef struct packed {
    logic                   is_rx;
    logic [7:0]             cmd_byte;
    logic                   cmd_last;
    logic                   rx_ok;
    logic [MOTOR_IDX_W-1:0] rx_motor;
    logic [31:0]            rx_position;
  } mcf_item_t;

  // position limits as seen by the back end
  typedef struct packed {
    logic [LIMIT_MOTORS-1:0]       valid;
    logic [LIMIT_MOTORS-1:0][31:0] min_pos;
    logic [LIMIT_MOTORS-1:0][31:0] max_pos;
  } mcf_limits_t;

  // queue head handed to the back end
  typedef struct packed {
    logic      valid;
    mcf_item_t item;
  } mcf_head_t;

endpackage

@@ rtl/mcf_front.sv @@
// mcf_front: classifies an input beat and decodes received position replies
// depends on mcf_pkg
module mcf_front import mcf_pkg::*; #(
  parameter int MOTOR_COUNT = 3
) (
  input  logic             in_req_type,
  input  logic [7:0]       in_cmd_byte,
  input  logic             in_cmd_last,
  input  logic [28:0]      in_rx_ident,
  input  logic             in_rx_extended,
  input  logic [3:0]       in_rx_count,
  input  logic [63:0]      in_rx_bytes,
  output mcf_item_t        item
);

  logic [7:0]  rx_addr;
  logic [31:0] mag;
  logic        reply_ok;

  assign rx_addr = in_rx_ident[15:8];
  // big endian magnitude in bytes 2..5
  assign mag = {in_rx_bytes[23:16], in_rx_bytes[31:24], in_rx_bytes[39:32],
                in_rx_bytes[47:40]};

  assign reply_ok = in_rx_extended
                 && (rx_addr < 8'(MOTOR_COUNT))
                 && (in_rx_count >= REPLY_MIN_LEN)
                 && (in_rx_bytes[7:0] == REPLY_HEAD)
                 && (in_rx_bytes[55:48] == REPLY_TAIL);

  always_comb begin
    item             = '0;
    item.is_rx       = in_req_type;
    item.cmd_byte    = in_cmd_byte;
    item.cmd_last    = in_cmd_last;
    item.rx_ok       = reply_ok;
    item.rx_motor    = rx_addr[MOTOR_IDX_W-1:0];
    // nonzero sign byte negates the magnitude
    item.rx_position = (in_rx_bytes[15:8] != 8'h00) ? (32'd0 - mag) : mag;
  end

endmodule

@@ rtl/mcf_queue.sv @@
// mcf_queue: short fifo of classified items between front and back
// depends on mcf_pkg
module mcf_queue import mcf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  mcf_item_t push_item,
  output logic      full,
  input  logic      pop,
  output mcf_head_t head
);

  mcf_item_t              entry_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;
  logic                   do_push, do_pop;

  assign full    = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.item  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  // occupancy and pointers stay consistent
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

endmodule

@@ rtl/mcf_back.sv @@
// mcf_back: command framing, limit guard, position tracking and result register
// depends on mcf_pkg
module mcf_back import mcf_pkg::*; #(
  parameter int MOTOR_COUNT = 3,
  parameter int FRAME_BYTES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mcf_head_t          head,
  output logic               pop,
  input  mcf_limits_t        limits,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_result_kind,
  output logic [15:0]        out_tx_ident,
  output logic [3:0]         out_tx_count,
  output logic [63:0]        out_tx_bytes,
  output logic               out_tx_final,
  output logic               out_motion_blocked,
  output logic               out_rx_accepted,
  output logic [1:0]         out_report_motor,
  output logic signed [31:0] out_report_position,
  output logic [31:0]        out_report_sequence
);

  localparam int         MW          = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam logic [3:0] FILL_FULL   = 4'(FRAME_BYTES);
  localparam logic [15:0] GUARD_INDEX = 16'(FRAME_BYTES);

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] tx_ident;
    logic [3:0]  tx_count;
    logic [63:0] tx_bytes;
    logic        tx_final;
    logic        motion_blocked;
    logic        rx_accepted;
    logic [1:0]  report_motor;
    logic [31:0] report_position;
    logic [31:0] report_sequence;
  } res_t;

  // command state
  logic [15:0] byte_count_r, byte_count_nxt;
  logic [7:0]  cmd_address_r, cmd_address_nxt;
  logic [7:0]  func_code_r, func_code_nxt;
  logic [63:0] frame_buffer_r, frame_buffer_nxt;
  logic [3:0]  frame_fill_r, frame_fill_nxt;
  logic [7:0]  packet_number_r, packet_number_nxt;

  // per motor state
  logic [31:0] motor_position_r [MOTOR_COUNT];
  logic [31:0] reply_sequence_r [MOTOR_COUNT];

  // result register
  logic        out_valid_r, out_valid_nxt;
  res_t        result_r, result_nxt;
  logic        res_valid;

  mcf_item_t   it;
  logic [MW-1:0] rd_idx;
  logic [31:0] cur_pos, cur_seq, seq_inc;
  logic [1:0]  lim_sel;
  logic        cmd_in_range, allowed, guard_hit, frame_done, pos_we;
  logic [63:0] buf_new, tx_buf;
  logic [3:0]  fill_new;
  logic [7:0]  dir;

  assign it  = head.item;
  assign pop = head.valid && (!out_valid_r || out_ready);

  // one read port into the motor state, shared by guard and reply update
  assign rd_idx  = it.is_rx ? it.rx_motor[MW-1:0] : cmd_address_r[MW-1:0];
  assign cur_pos = motor_position_r[rd_idx];
  assign cur_seq = reply_sequence_r[rd_idx];
  assign seq_inc = cur_seq + 32'd1;

  assign cmd_in_range = (cmd_address_r < 8'(LIMIT_MOTORS))
                     && (cmd_address_r < 8'(MOTOR_COUNT));
  assign lim_sel = cmd_in_range ? cmd_address_r[1:0] : 2'd0;

  // byte lane insert at the current fill point
  always_comb begin
    buf_new = frame_buffer_r;
    for (int k = 0; k < 8; k++) begin
      if (frame_fill_r[2:0] == 3'(k)) begin
        buf_new[8*k +: 8] = frame_buffer_r[8*k +: 8] | it.cmd_byte;
      end
    end
  end

  assign fill_new   = frame_fill_r + 4'd1;
  assign frame_done = (fill_new >= FILL_FULL) || it.cmd_last;
  assign dir        = buf_new[15:8];

  assign allowed = cmd_in_range
                && limits.valid[lim_sel]
                && (cur_seq != 32'd0)
                && !((dir == 8'h00)
                     && ($signed(cur_pos) >= $signed(limits.max_pos[lim_sel])))
                && !((dir != 8'h00)
                     && ($signed(cur_pos) <= $signed(limits.min_pos[lim_sel])));

  assign guard_hit = (byte_count_r == GUARD_INDEX) && (fill_new >= FILL_FULL)
                  && (cmd_address_r < 8'(LIMIT_MOTORS))
                  && (func_code_r == VELOCITY_FN) && !allowed;

  // speed bytes cleared when the guard trips
  always_comb begin
    tx_buf = buf_new;
    if (guard_hit) begin
      for (int p = GUARD_LO; p <= GUARD_HI; p++) begin
        if (p < FRAME_BYTES) begin
          tx_buf[8*p +: 8] = 8'h00;
        end
      end
    end
  end

  always_comb begin
    byte_count_nxt    = byte_count_r;
    cmd_address_nxt   = cmd_address_r;
    func_code_nxt     = func_code_r;
    frame_buffer_nxt  = frame_buffer_r;
    frame_fill_nxt    = frame_fill_r;
    packet_number_nxt = packet_number_r;
    result_nxt        = '0;
    res_valid         = 1'b0;
    pos_we            = 1'b0;

    if (pop) begin
      if (it.is_rx) begin
        res_valid       = 1'b1;
        result_nxt.kind = KIND_RX;
        if (it.rx_ok) begin
          pos_we                     = 1'b1;
          result_nxt.rx_accepted     = 1'b1;
          result_nxt.report_motor    = it.rx_motor[1:0];
          result_nxt.report_position = it.rx_position;
          result_nxt.report_sequence = seq_inc;
        end
      end else begin
        byte_count_nxt = (byte_count_r != 16'hFFFF) ? byte_count_r + 16'd1 : byte_count_r;
        if (byte_count_r == 16'd0) begin
          cmd_address_nxt = it.cmd_byte;
          if (it.cmd_last) begin
            // address only: nothing to send
            res_valid       = 1'b1;
            result_nxt.kind = KIND_ERR;
          end
        end else if (byte_count_r == 16'd1) begin
          func_code_nxt     = it.cmd_byte;
          frame_buffer_nxt  = {56'd0, it.cmd_byte};
          frame_fill_nxt    = 4'd1;
          packet_number_nxt = 8'd0;
          if (it.cmd_last) begin
            res_valid           = 1'b1;
            result_nxt.kind     = KIND_TX;
            result_nxt.tx_ident = {cmd_address_r, 8'd0};
            result_nxt.tx_count = 4'd1;
            result_nxt.tx_bytes = {56'd0, it.cmd_byte};
            result_nxt.tx_final = 1'b1;
          end
        end else begin
          frame_buffer_nxt = buf_new;
          frame_fill_nxt   = fill_new;
          if (frame_done) begin
            res_valid                 = 1'b1;
            result_nxt.kind           = KIND_TX;
            result_nxt.tx_ident       = {cmd_address_r, packet_number_r};
            result_nxt.tx_count       = fill_new;
            result_nxt.tx_bytes       = tx_buf;
            result_nxt.tx_final       = it.cmd_last;
            result_nxt.motion_blocked = guard_hit;
            if (!it.cmd_last) begin
              frame_buffer_nxt  = {56'd0, func_code_r};
              frame_fill_nxt    = 4'd1;
              packet_number_nxt = packet_number_r + 8'd1;
            end
          end
        end
        if (it.cmd_last) begin
          // back to idle
          byte_count_nxt    = 16'd0;
          cmd_address_nxt   = 8'd0;
          func_code_nxt     = 8'd0;
          frame_buffer_nxt  = 64'd0;
          frame_fill_nxt    = 4'd0;
          packet_number_nxt = 8'd0;
        end
      end
    end

    if (pop) begin
      out_valid_nxt = res_valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r    <= '0;
      cmd_address_r   <= '0;
      func_code_r     <= '0;
      frame_buffer_r  <= '0;
      frame_fill_r    <= '0;
      packet_number_r <= '0;
      out_valid_r     <= 1'b0;
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        motor_position_r[m] <= '0;
        reply_sequence_r[m] <= '0;
      end
    end else begin
      byte_count_r    <= byte_count_nxt;
      cmd_address_r   <= cmd_address_nxt;
      func_code_r     <= func_code_nxt;
      frame_buffer_r  <= frame_buffer_nxt;
      frame_fill_r    <= frame_fill_nxt;
      packet_number_r <= packet_number_nxt;
      out_valid_r     <= out_valid_nxt;
      if (pos_we) begin
        motor_position_r[rd_idx] <= it.rx_position;
        reply_sequence_r[rd_idx] <= seq_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = result_r.kind;
  assign out_tx_ident        = result_r.tx_ident;
  assign out_tx_count        = result_r.tx_count;
  assign out_tx_bytes        = result_r.tx_bytes;
  assign out_tx_final        = result_r.tx_final;
  assign out_motion_blocked  = result_r.motion_blocked;
  assign out_rx_accepted     = result_r.rx_accepted;
  assign out_report_motor    = result_r.report_motor;
  assign out_report_position = $signed(result_r.report_position);
  assign out_report_sequence = result_r.report_sequence;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    frame_fill_r < FILL_FULL)
    else $error("frame fill reached full while holding");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_count_r == 16'd0) |-> (frame_fill_r == 4'd0) && (packet_number_r == 8'd0))
    else $error("idle command with leftover frame state");

  a_tx_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (result_r.kind == KIND_TX))
      |-> (result_r.tx_count != 4'd0) && (result_r.tx_count <= FILL_FULL))
    else $error("frame length out of range");

  a_blocked_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && result_r.motion_blocked)
      |-> (result_r.kind == KIND_TX) && (result_r.tx_ident[7:0] == 8'd0))
    else $error("guard fired outside the first frame");

endmodule

@@ rtl/motor_can_command_framer.sv @@
// motor_can_command_framer: top level, register file and front/queue/back wiring
// depends on mcf_pkg, mcf_front, mcf_queue, mcf_back
//
//  channel  | dir | handshake                  | beat
//  ---------+-----+----------------------------+--------------------------------
//  in_      | in  | in_valid / in_ready        | command byte or received frame
//  out_     | out | out_valid / out_ready      | tx frame, rx report or error
//  config   | in  | psel penable pwrite pready | one 32 bit register write/read
//
// one beat per cycle is accepted while the queue has room, and one result per
// cycle is delivered while out_ready is high; each beat is classified by the
// combinational front as it is accepted, sits in the two-entry queue and is
// finished by the back end into the result register.
// with an empty queue out_valid rises once the back end registers the result.
// beats that cause no result (middle command bytes) are retired silently.
// rst_n is synchronous: command state, motor positions, reply counts and
// the limit registers all clear; no clearing pass is needed.
// an out_ready stall fills the queue; in_ready drops only when it is full.
module motor_can_command_framer import mcf_pkg::*; #(
  parameter int MOTOR_COUNT = 3,
  parameter int FRAME_BYTES = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [7:0]            in_cmd_byte,
  input  logic                  in_cmd_last,
  input  logic [28:0]           in_rx_ident,
  input  logic                  in_rx_extended,
  input  logic [3:0]            in_rx_count,
  input  logic [63:0]           in_rx_bytes,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_result_kind,
  output logic [15:0]           out_tx_ident,
  output logic [3:0]            out_tx_count,
  output logic [63:0]           out_tx_bytes,
  output logic                  out_tx_final,
  output logic                  out_motion_blocked,
  output logic                  out_rx_accepted,
  output logic [1:0]            out_report_motor,
  output logic signed [31:0]    out_report_position,
  output logic [31:0]           out_report_sequence,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // limit registers
  logic [LIMIT_MOTORS-1:0][31:0] min_pos_r;
  logic [LIMIT_MOTORS-1:0][31:0] max_pos_r;
  logic [LIMIT_MOTORS-1:0]       limits_valid_r;
  logic                          cfg_wr;
  logic [2:0]                    reg_idx;
  mcf_limits_t                   limits;

  // front to queue to back
  mcf_item_t front_item;
  mcf_head_t head;
  logic      q_full, q_pop;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pos_r      <= '0;
      max_pos_r      <= '0;
      limits_valid_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MIN_POS_M0:   min_pos_r[0]   <= pwdata;
        REG_MAX_POS_M0:   max_pos_r[0]   <= pwdata;
        REG_MIN_POS_M1:   min_pos_r[1]   <= pwdata;
        REG_MAX_POS_M1:   max_pos_r[1]   <= pwdata;
        REG_MIN_POS_M2:   min_pos_r[2]   <= pwdata;
        REG_MAX_POS_M2:   max_pos_r[2]   <= pwdata;
        REG_LIMITS_VALID: limits_valid_r <= pwdata[LIMIT_MOTORS-1:0];
        default:          ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_MIN_POS_M0:   prdata = min_pos_r[0];
      REG_MAX_POS_M0:   prdata = max_pos_r[0];
      REG_MIN_POS_M1:   prdata = min_pos_r[1];
      REG_MAX_POS_M1:   prdata = max_pos_r[1];
      REG_MIN_POS_M2:   prdata = min_pos_r[2];
      REG_MAX_POS_M2:   prdata = max_pos_r[2];
      REG_LIMITS_VALID: prdata = {{(32-LIMIT_MOTORS){1'b0}}, limits_valid_r};
      default:          prdata = 32'd0;
    endcase
  end

  assign limits.valid   = limits_valid_r;
  assign limits.min_pos = min_pos_r;
  assign limits.max_pos = max_pos_r;

  // classify the incoming beat
  mcf_front #(
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_front (
    .in_req_type    (in_req_type),
    .in_cmd_byte    (in_cmd_byte),
    .in_cmd_last    (in_cmd_last),
    .in_rx_ident    (in_rx_ident),
    .in_rx_extended (in_rx_extended),
    .in_rx_count    (in_rx_count),
    .in_rx_bytes    (in_rx_bytes),
    .item           (front_item)
  );

  // accept whenever the queue has room
  assign in_ready = !q_full;

  mcf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (head)
  );

  // framing, guard and reply tracking in stream order
  mcf_back #(
    .MOTOR_COUNT (MOTOR_COUNT),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head                (head),
    .pop                 (q_pop),
    .limits              (limits),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_kind     (out_result_kind),
    .out_tx_ident        (out_tx_ident),
    .out_tx_count        (out_tx_count),
    .out_tx_bytes        (out_tx_bytes),
    .out_tx_final        (out_tx_final),
    .out_motion_blocked  (out_motion_blocked),
    .out_rx_accepted     (out_rx_accepted),
    .out_report_motor    (out_report_motor),
    .out_report_position (out_report_position),
    .out_report_sequence (out_report_sequence)
  );

endmodule
